/* hw/rtl/ccq_pkg.sv */
// Shared types and command codes for the coalescing command queue.
package ccq_pkg;

    localparam logic KIND_POST = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    localparam logic [2:0] CMD_LOAD     = 3'd0;
    localparam logic [2:0] CMD_UNLOAD   = 3'd1;
    localparam logic [2:0] CMD_RESIZE   = 3'd2;
    localparam logic [2:0] CMD_RENDER   = 3'd3;
    localparam logic [2:0] CMD_SNAPSHOT = 3'd4;
    localparam logic [2:0] CMD_CALLBACK = 3'd5;
    localparam logic [2:0] CMD_QUIT     = 3'd6;

    typedef struct packed {
        logic        valid;
        logic [2:0]  cmd_type;
        logic [63:0] payload;
    } t_entry;

    typedef struct packed {
        logic shift_all;
        logic merge_shift;
        logic match_en;
        logic write;
    } t_cell_ctl;

endpackage

/* hw/rtl/coalescing_command_queue.sv */
// Top level of the coalescing command queue built as a collapsing chain of slots.
// The result of an accepted input transaction is registered and shown in the cycle after it is accepted.
// Throughput is one transaction per cycle while the result side keeps taking results.
// The cycle time is set by the type-match chain that runs through all slots.
// Synchronous active-low reset empties the queue and clears quit and the output valid flag.
module coalescing_command_queue
    import ccq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  logic [2:0]  i_cmd_type,
    input  logic [63:0] i_cmd_payload,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_pop_valid,
    output logic [2:0]  o_pop_type,
    output logic [63:0] o_pop_payload,
    output logic        o_dropped_valid,
    output logic [2:0]  o_dropped_type,
    output logic [63:0] o_dropped_payload,
    output logic [4:0]  o_occupancy,
    output logic        o_quit_pending
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_quit;
    logic          n_quit;
    logic          r_out_valid;
    t_entry        r_pop;
    t_entry        n_pop;
    t_entry        r_drop;
    t_entry        n_drop;
    logic [4:0]    r_occ;

    t_entry        w_entry [QUEUE_DEPTH];
    t_entry        w_dchain [QUEUE_DEPTH+1];
    logic [QUEUE_DEPTH:0]   w_seen;
    logic [QUEUE_DEPTH-1:0] w_valid;
    t_cell_ctl     w_ctl [QUEUE_DEPTH];

    logic          w_accept;
    logic          w_pop;
    logic          w_post;
    logic          w_coal;
    logic          w_merged;
    logic          w_over;
    logic          w_empty;
    logic [CW-1:0] w_tail;
    logic [CW+4:0] w_cnt_ext;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_pop      = w_accept && (i_kind == KIND_POP);
    assign w_post     = w_accept && (i_kind == KIND_POST) && (i_cmd_type <= CMD_CALLBACK);
    assign w_coal     = w_post && (i_cmd_type <= CMD_RENDER);
    assign w_merged   = w_seen[QUEUE_DEPTH];
    assign w_empty    = (r_count == '0);
    assign w_over     = w_post && !w_merged && (r_count == CW'(QUEUE_DEPTH));

    always_comb begin
        if (w_merged) begin
            w_tail = r_count - CW'(1);
        end else if (w_over) begin
            w_tail = CW'(QUEUE_DEPTH - 1);
        end else begin
            w_tail = r_count;
        end
    end

    assign w_seen[0]   = 1'b0;
    assign w_dchain[0] = '0;

    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
        t_entry w_next;

        if (gi < QUEUE_DEPTH - 1) begin : g_mid
            assign w_next = w_entry[gi+1];
        end else begin : g_last
            assign w_next = '0;
        end

        assign w_ctl[gi].shift_all   = w_pop || w_over;
        assign w_ctl[gi].merge_shift = w_coal;
        assign w_ctl[gi].match_en    = w_coal;
        assign w_ctl[gi].write       = w_post && (w_tail == CW'(gi));
        assign w_valid[gi]           = w_entry[gi].valid;

        ccq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl[gi]),
            .i_cmd_type    (i_cmd_type),
            .i_cmd_payload (i_cmd_payload),
            .i_next        (w_next),
            .i_seen        (w_seen[gi]),
            .i_drop        (w_dchain[gi]),
            .o_entry       (w_entry[gi]),
            .o_seen        (w_seen[gi+1]),
            .o_drop        (w_dchain[gi+1])
        );
    end

    always_comb begin
        n_count = r_count;
        n_quit  = r_quit;
        n_pop   = '0;
        n_drop  = '0;
        if (w_pop) begin
            if (!w_empty) begin
                n_pop   = w_entry[0];
                n_count = r_count - CW'(1);
            end else if (r_quit) begin
                n_pop = '{valid: 1'b1, cmd_type: CMD_QUIT, payload: 64'd0};
            end
        end else if (w_accept && (i_cmd_type == CMD_QUIT)) begin
            n_quit = 1'b1;
        end else if (w_post) begin
            if (w_merged) begin
                n_drop       = w_dchain[QUEUE_DEPTH];
                n_drop.valid = 1'b1;
            end else if (w_over) begin
                n_drop = w_entry[0];
            end else begin
                n_count = r_count + CW'(1);
            end
        end
    end

    assign w_cnt_ext = (CW+5)'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_quit      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_quit  <= n_quit;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pop  <= n_pop;
            r_drop <= n_drop;
            r_occ  <= w_cnt_ext[4:0];
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_pop_valid       = r_pop.valid;
    assign o_pop_type        = r_pop.cmd_type;
    assign o_pop_payload     = r_pop.payload;
    assign o_dropped_valid   = r_drop.valid;
    assign o_dropped_type    = r_drop.cmd_type;
    assign o_dropped_payload = r_drop.payload;
    assign o_occupancy       = r_occ;
    assign o_quit_pending    = r_quit;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("Queue count exceeds the depth.");

    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("Occupied slots disagree with the queue count.");

    a_quit_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_quit |=> r_quit)
        else $error("Quit flag cleared without reset.");

    a_pop_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_pop.valid && r_drop.valid))
        else $error("One transaction both popped and dropped an entry.");
`endif

endmodule

/* hw/rtl/ccq_cell.sv */
// One queue slot: holds an entry, compares its type and shifts toward the head.
module ccq_cell
    import ccq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cell_ctl   i_ctl,
    input  logic [2:0]  i_cmd_type,
    input  logic [63:0] i_cmd_payload,
    input  t_entry      i_next,
    input  logic        i_seen,
    input  t_entry      i_drop,
    output t_entry      o_entry,
    output logic        o_seen,
    output t_entry      o_drop
);

    logic        r_valid;
    logic [2:0]  r_type;
    logic [63:0] r_payload;
    logic        w_match;
    logic        w_shift;

    assign w_match = r_valid && i_ctl.match_en && (r_type == i_cmd_type);
    assign o_seen  = i_seen || w_match;
    assign o_entry = '{valid: r_valid, cmd_type: r_type, payload: r_payload};
    assign o_drop  = (w_match && !i_seen) ? o_entry : i_drop;
    assign w_shift = i_ctl.shift_all || (i_ctl.merge_shift && o_seen);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.write) begin
            r_valid <= 1'b1;
        end else if (w_shift) begin
            r_valid <= i_next.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.write) begin
            r_type    <= i_cmd_type;
            r_payload <= i_cmd_payload;
        end else if (w_shift) begin
            r_type    <= i_next.cmd_type;
            r_payload <= i_next.payload;
        end
    end

endmodule
